// ===== rtl/ctd_pkg.sv =====
// Shared types and constants for the degree-input Taylor cosine pipeline.
// Used by every module under rtl/; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

    localparam int ANGLE_W          = 16;   // signed whole degrees
    localparam int OUT_W            = 18;   // signed Q2.16 result
    localparam int OUT_TDATA_W      = 24;   // result padded to whole bytes
    localparam int SERIES_TERMS_DEF = 11;

    // angle folding
    localparam int DEG_W           = 9;     // folded angle 0..360
    localparam int QD_W            = 7;     // |angle| / 360 <= 91
    localparam int RECIP360_SHIFT  = 24;
    localparam logic [ANGLE_W-1:0] RECIP360  = 16'd46604;   // ceil(2^24 / 360)
    localparam logic [DEG_W-1:0]   FULL_TURN = 9'd360;

    // radians and square
    localparam int RAD_W = 27;
    localparam logic [RAD_W-1:0] RAD_PER_DEG = 27'd74961321;  // round(pi/180 * 2^32)
    localparam int XP_W  = 36;              // d * RAD_PER_DEG + rounding
    localparam int X_W   = 19;              // radians, Q3.16
    localparam int SQ_W  = 2 * X_W;
    localparam int Y_W   = 22;              // x^2, Q16

    // Horner datapath
    localparam int P_W    = 40;             // signed Q30 partial sum
    localparam int HALF_W = P_W / 2;        // operand split for the y * |p| product
    localparam int N_W    = Y_W + P_W;      // full product width
    localparam int T_W    = 48;             // scaled numerator, whole chunks
    localparam int CH_W   = 16;             // long-division chunk
    localparam logic [P_W-1:0] ONE_Q30 = P_W'(1) << 30;

    // output rounding: Q30 -> Q16
    localparam int RND_SHIFT = 14;
    localparam int RQ_W      = P_W - RND_SHIFT;
    localparam logic [P_W-1:0]  RND_HALF = P_W'(1) << (RND_SHIFT - 1);
    localparam logic [RQ_W-1:0] POS_LIMIT = RQ_W'(131071);
    localparam logic [RQ_W-1:0] NEG_LIMIT = RQ_W'(131072);
    localparam logic [OUT_W-1:0] OUT_MAX = 18'h1FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 18'h20000;

    // one item traveling down the Horner chain
    typedef struct packed {
        logic                  valid;
        logic [Y_W-1:0]        y;
        logic signed [P_W-1:0] p;
    } hbus_t;

endpackage

`default_nettype wire

// ===== rtl/ctd_cdiv.sv =====
// Pipelined exact division of an unsigned word by a constant, 16 bits a step.
// Each step is a reciprocal multiply then a remainder fix; depends on ctd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctd_cdiv import ctd_pkg::*; #(
    parameter int DIVISOR = 2,
    parameter int SIDE_W  = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [T_W-1:0]    in_t,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [T_W-1:0]         out_q,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int NCH     = T_W / CH_W;
    localparam int R_W     = $clog2(DIVISOR);
    localparam int NUM_W   = R_W + CH_W;
    localparam int S_W     = CH_W + 2 * R_W;   // num * error < 2^S_W keeps it exact
    localparam int PROD_W  = NUM_W + S_W;
    localparam logic [63:0] MUL_FULL =
        ((64'd1 << S_W) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [S_W-1:0] MUL = MUL_FULL[S_W-1:0];

    // stage a: reciprocal product
    logic              va_reg    [NCH];
    logic [NUM_W-1:0]  numa_reg  [NCH];
    logic [PROD_W-1:0] proda_reg [NCH];
    logic [T_W-1:0]    ta_reg    [NCH];
    logic [T_W-1:0]    qa_reg    [NCH];
    logic [SIDE_W-1:0] sidea_reg [NCH];
    // stage b: quotient digit and remainder
    logic              vb_reg    [NCH];
    logic [R_W-1:0]    remb_reg  [NCH];
    logic [T_W-1:0]    tb_reg    [NCH];
    logic [T_W-1:0]    qb_reg    [NCH];
    logic [SIDE_W-1:0] sideb_reg [NCH];

    for (genvar j = 0; j < NCH; j++) begin : g_chunk
        logic              src_v;
        logic [R_W-1:0]    src_rem;
        logic [T_W-1:0]    src_t;
        logic [T_W-1:0]    src_q;
        logic [SIDE_W-1:0] src_side;
        logic [NUM_W-1:0]  num;
        logic [CH_W-1:0]   qi;
        logic [NUM_W-1:0]  qc;
        logic [NUM_W-1:0]  rem_full;

        if (j == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_rem  = '0;
            assign src_t    = in_t;
            assign src_q    = '0;
            assign src_side = in_side;
        end else begin : g_next
            assign src_v    = vb_reg[j-1];
            assign src_rem  = remb_reg[j-1];
            assign src_t    = tb_reg[j-1];
            assign src_q    = qb_reg[j-1];
            assign src_side = sideb_reg[j-1];
        end

        // most significant chunk first
        assign num = {src_rem, src_t[T_W-1-j*CH_W -: CH_W]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg[j] <= 1'b0;
            end else if (en) begin
                va_reg[j] <= src_v;
            end
            if (en) begin
                numa_reg[j]  <= num;
                proda_reg[j] <= PROD_W'(num) * PROD_W'(MUL);
                ta_reg[j]    <= src_t;
                qa_reg[j]    <= src_q;
                sidea_reg[j] <= src_side;
            end
        end

        assign qi       = proda_reg[j][S_W +: CH_W];
        assign qc       = NUM_W'(qi) * NUM_W'(DIVISOR);
        assign rem_full = numa_reg[j] - qc;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vb_reg[j] <= 1'b0;
            end else if (en) begin
                vb_reg[j] <= va_reg[j];
            end
            if (en) begin
                remb_reg[j]  <= rem_full[R_W-1:0];
                tb_reg[j]    <= ta_reg[j];
                qb_reg[j]    <= {qa_reg[j][T_W-CH_W-1:0], qi};
                sideb_reg[j] <= sidea_reg[j];
            end
        end

        // the reciprocal must give the exact digit, so the remainder stays below the divisor
        assert property (@(posedge aclk) disable iff (!aresetn)
            vb_reg[j] |-> ({1'b0, remb_reg[j]} < (R_W + 1)'(DIVISOR)))
            else $error("ctd_cdiv: remainder not below divisor");
    end

    assign out_valid = vb_reg[NCH-1];
    assign out_q     = qb_reg[NCH-1];
    assign out_side  = sideb_reg[NCH-1];

endmodule

`default_nettype wire

// ===== rtl/ctd_term.sv =====
// One Horner step: p <- 1 - round(y * p / ((2K-1) * 2K * 2^16)), in Q30.
// Depends on ctd_pkg and ctd_cdiv.
`timescale 1ns / 1ps
`default_nettype none

module ctd_term import ctd_pkg::*; #(
    parameter int K = 1
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire hbus_t in_bus,
    output hbus_t      out_bus
);

    localparam int DIV    = (2 * K - 1) * (2 * K);
    localparam int SIDE_W = Y_W + 1;
    localparam logic [T_W-1:0] HALF_DIV = T_W'(DIV / 2);

    // stage 1: sign and magnitude of p
    logic           v1_reg;
    logic           neg1_reg;
    logic [P_W-1:0] mag1_reg;
    logic [Y_W-1:0] y1_reg;
    logic [P_W-1:0] p_bits;
    logic [P_W-1:0] mag1_next;

    assign p_bits    = in_bus.p;
    assign mag1_next = p_bits[P_W-1] ? (~p_bits + 1'b1) : p_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_bus.valid;
        end
        if (en) begin
            neg1_reg <= p_bits[P_W-1];
            mag1_reg <= mag1_next;
            y1_reg   <= in_bus.y;
        end
    end

    // stage 2: y * |p| as two partial products
    logic                  v2_reg;
    logic                  neg2_reg;
    logic [Y_W-1:0]        y2_reg;
    logic [Y_W+HALF_W-1:0] plo2_reg;
    logic [Y_W+HALF_W-1:0] phi2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            neg2_reg <= neg1_reg;
            y2_reg   <= y1_reg;
            plo2_reg <= (Y_W + HALF_W)'(y1_reg) * (Y_W + HALF_W)'(mag1_reg[HALF_W-1:0]);
            phi2_reg <= (Y_W + HALF_W)'(y1_reg) * (Y_W + HALF_W)'(mag1_reg[P_W-1:HALF_W]);
        end
    end

    // stage 3: combine, drop 16 bits, add half the divisor for round-to-nearest
    logic           v3_reg;
    logic           neg3_reg;
    logic [Y_W-1:0] y3_reg;
    logic [T_W-1:0] t3_reg;
    logic [N_W-1:0] prod_sum;

    assign prod_sum = {phi2_reg, {HALF_W{1'b0}}} + N_W'(plo2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            neg3_reg <= neg2_reg;
            y3_reg   <= y2_reg;
            t3_reg   <= T_W'(prod_sum[N_W-1:16]) + HALF_DIV;
        end
    end

    logic              vd;
    logic [T_W-1:0]    qd;
    logic [SIDE_W-1:0] sided;

    ctd_cdiv #(
        .DIVISOR (DIV),
        .SIDE_W  (SIDE_W)
    ) u_cdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_t      (t3_reg),
        .in_side   ({y3_reg, neg3_reg}),
        .out_valid (vd),
        .out_q     (qd),
        .out_side  (sided)
    );

    // last stage: p = 1 - signed quotient
    logic           v4_reg;
    logic [Y_W-1:0] y4_reg;
    logic [P_W-1:0] p4_reg;
    logic [P_W-1:0] q_low;

    assign q_low = qd[P_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= vd;
        end
        if (en) begin
            y4_reg <= sided[SIDE_W-1:1];
            p4_reg <= sided[0] ? (ONE_Q30 + q_low) : (ONE_Q30 - q_low);
        end
    end

    assign out_bus.valid = v4_reg;
    assign out_bus.y     = y4_reg;
    assign out_bus.p     = signed'(p4_reg);

endmodule

`default_nettype wire

// ===== rtl/ctd_front.sv =====
// Front end: fold the degree angle into 0..360, convert to Q3.16 radians, square.
// Six register stages; depends on ctd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctd_front import ctd_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [ANGLE_W-1:0] angle,
    output hbus_t                   out_bus
);

    // F1: magnitude and range flags
    logic               v1_reg;
    logic               neg1_reg;
    logic               big1_reg;
    logic [ANGLE_W-1:0] mag1_reg;
    logic [DEG_W-1:0]   low1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            neg1_reg <= angle[ANGLE_W-1];
            big1_reg <= !angle[ANGLE_W-1] && (angle > ANGLE_W'(FULL_TURN));
            mag1_reg <= angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;
            low1_reg <= angle[DEG_W-1:0];
        end
    end

    // F2: reciprocal product for |a| / 360
    logic                 v2_reg;
    logic                 neg2_reg;
    logic                 big2_reg;
    logic [ANGLE_W-1:0]   mag2_reg;
    logic [DEG_W-1:0]     low2_reg;
    logic [2*ANGLE_W-1:0] prod2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            neg2_reg  <= neg1_reg;
            big2_reg  <= big1_reg;
            mag2_reg  <= mag1_reg;
            low2_reg  <= low1_reg;
            prod2_reg <= (2 * ANGLE_W)'(mag1_reg) * (2 * ANGLE_W)'(RECIP360);
        end
    end

    // F3: remainder |a| mod 360
    logic               v3_reg;
    logic               neg3_reg;
    logic               big3_reg;
    logic [DEG_W-1:0]   low3_reg;
    logic [DEG_W-1:0]   r3_reg;
    logic [QD_W-1:0]    turns;
    logic [ANGLE_W-1:0] turns_deg;
    logic [ANGLE_W-1:0] r_full;

    assign turns     = prod2_reg[RECIP360_SHIFT +: QD_W];
    assign turns_deg = ANGLE_W'(turns) * ANGLE_W'(FULL_TURN);
    assign r_full    = mag2_reg - turns_deg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            neg3_reg <= neg2_reg;
            big3_reg <= big2_reg;
            low3_reg <= low2_reg;
            r3_reg   <= r_full[DEG_W-1:0];
        end
    end

    // F4: folded angle; a negative multiple of 360 lands on 360, not 0
    logic             v4_reg;
    logic [DEG_W-1:0] d4_reg;
    logic [DEG_W-1:0] d4_next;

    always_comb begin
        priority if (neg3_reg) begin
            d4_next = FULL_TURN - r3_reg;
        end else if (big3_reg) begin
            d4_next = r3_reg;
        end else begin
            d4_next = low3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            d4_reg <= d4_next;
        end
    end

    // F5: radians, Q3.16, rounded
    logic            v5_reg;
    logic [X_W-1:0]  x5_reg;
    logic [XP_W-1:0] x_prod;

    assign x_prod = XP_W'(d4_reg) * XP_W'(RAD_PER_DEG) + XP_W'(32768);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            x5_reg <= x_prod[16 +: X_W];
        end
    end

    // F6: y = x^2 in Q16, rounded
    logic            v6_reg;
    logic [Y_W-1:0]  y6_reg;
    logic [SQ_W-1:0] x_sq;

    assign x_sq = SQ_W'(x5_reg) * SQ_W'(x5_reg) + SQ_W'(32768);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
        if (en) begin
            y6_reg <= x_sq[16 +: Y_W];
        end
    end

    assign out_bus.valid = v6_reg;
    assign out_bus.y     = y6_reg;
    assign out_bus.p     = signed'(ONE_Q30);

    assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (r3_reg < FULL_TURN))
        else $error("ctd_front: mod 360 remainder out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (d4_reg <= FULL_TURN))
        else $error("ctd_front: folded angle above 360");

endmodule

`default_nettype wire

// ===== rtl/cosine_taylor_degrees.sv =====
// Top level: degree angle in, truncated Taylor cosine (signed Q2.16) out.
// Depends on ctd_pkg, ctd_front, ctd_term (with ctd_cdiv) .
//
//  port group        | dir | tdata bits (low to high)
//  ------------------+-----+-----------------------------------------
//  s_tvalid/tready   | in  | [15:0] angle_degrees, signed
//  m_tvalid/tready   | out | [17:0] cosine_value, signed Q2.16; [23:18] zero
//
// The path runs through six front stages, ten per Horner step (abs, split multiply,
// combine, three two-stage division chunks, update), two rounding stages and the output
// register. One transfer per clock is sustained unless the output buffer is full;
// every stage is a register with its own valid.
// Reset clears the valid bits and the output buffer count; payload is not reset.
// The pipeline holds only when the two-entry output buffer is full, so s_tready
// comes from a register and input is still taken while one result waits.
`timescale 1ns / 1ps
`default_nettype none

module cosine_taylor_degrees import ctd_pkg::*; #(
    parameter int SERIES_TERMS = SERIES_TERMS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [ANGLE_W-1:0]     s_tdata,   // [15:0] angle_degrees
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // [17:0] cosine_value
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       en;

    assign en       = (count_reg != CNT_FULL);
    assign s_tready = en;

    // Horner chain, innermost term first
    hbus_t chain [SERIES_TERMS];

    ctd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .angle    (s_tdata),
        .out_bus  (chain[0])
    );

    for (genvar i = 0; i < SERIES_TERMS - 1; i++) begin : g_term
        ctd_term #(
            .K (SERIES_TERMS - 1 - i)
        ) u_term (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_bus  (chain[i]),
            .out_bus (chain[i+1])
        );
    end

    // E1: magnitude of the Q30 sum
    logic           e1_v_reg;
    logic           e1_neg_reg;
    logic [P_W-1:0] e1_mag_reg;
    logic [P_W-1:0] p_last;

    assign p_last = chain[SERIES_TERMS-1].p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_v_reg <= 1'b0;
        end else if (en) begin
            e1_v_reg <= chain[SERIES_TERMS-1].valid;
        end
        if (en) begin
            e1_neg_reg <= p_last[P_W-1];
            e1_mag_reg <= p_last[P_W-1] ? (~p_last + 1'b1) : p_last;
        end
    end

    // E2: round to Q16, halves away from zero
    logic            e2_v_reg;
    logic            e2_neg_reg;
    logic [RQ_W-1:0] e2_q_reg;
    logic [P_W-1:0]  rnd_sum;

    assign rnd_sum = e1_mag_reg + RND_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_v_reg <= 1'b0;
        end else if (en) begin
            e2_v_reg <= e1_v_reg;
        end
        if (en) begin
            e2_neg_reg <= e1_neg_reg;
            e2_q_reg   <= rnd_sum[P_W-1:RND_SHIFT];
        end
    end

    // saturate into Q2.16
    logic [OUT_W-1:0] result;

    always_comb begin
        if (e2_neg_reg) begin
            result = (e2_q_reg > NEG_LIMIT) ? OUT_MIN : (~e2_q_reg[OUT_W-1:0] + 1'b1);
        end else begin
            result = (e2_q_reg > POS_LIMIT) ? OUT_MAX : e2_q_reg[OUT_W-1:0];
        end
    end

    // two-entry output buffer: head drives m_tdata, skid catches one more transfer
    logic             push;
    logic             pop;
    logic [OUT_W-1:0] head_reg;
    logic [OUT_W-1:0] skid_reg;

    assign push = en && e2_v_reg;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        unique case (count_reg)
            CNT_EMPTY: count_next = push ? CNT_ONE : CNT_EMPTY;
            CNT_ONE: begin
                if (push && !pop) begin
                    count_next = CNT_FULL;
                end else if (!push && pop) begin
                    count_next = CNT_EMPTY;
                end
            end
            CNT_FULL:  count_next = pop ? CNT_ONE : CNT_FULL;
            default:   count_next = CNT_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_EMPTY;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (count_reg)
            CNT_EMPTY: begin
                if (push) begin
                    head_reg <= result;
                end
            end
            CNT_ONE: begin
                if (push && pop) begin
                    head_reg <= result;
                end else if (push) begin
                    skid_reg <= result;
                end
            end
            CNT_FULL: begin
                if (pop) begin
                    head_reg <= skid_reg;
                end
            end
            default: begin
                head_reg <= head_reg;
            end
        endcase
    end

    assign m_tvalid = (count_reg != CNT_EMPTY);
    assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, head_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_ONE && push && !pop) |=> (count_reg == CNT_FULL && !s_tready))
        else $error("cosine_taylor_degrees: output buffer did not fill");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (e2_v_reg && !en) |=> e2_v_reg)
        else $error("cosine_taylor_degrees: held result lost during stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_EMPTY) |-> !pop)
        else $error("cosine_taylor_degrees: transfer from empty output buffer");

endmodule

`default_nettype wire
